FILE: rtl/blist_pkg.sv
// Shared types and constants for the bounded ordered list.
// No dependencies; every other file in rtl/ imports this package.
package blist_pkg;

    localparam int CAPACITY = 16;
    localparam int VAL_W    = 32;
    localparam int OPC_W    = 4;
    localparam int POS_W    = 6;
    localparam int ST_W     = 2;
    localparam int LEN_W    = 5;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    // Width that holds both a position and a count without overflow.
    localparam int PCMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

    typedef enum logic [OPC_W-1:0] {
        OP_APPEND     = 4'd0,
        OP_PREPEND    = 4'd1,
        OP_INSERT     = 4'd2,
        OP_DROP_LAST  = 4'd3,
        OP_DROP_FIRST = 4'd4,
        OP_DROP_AT    = 4'd5,
        OP_REVERSE    = 4'd6,
        OP_MIDDLE     = 4'd7,
        OP_LIST       = 4'd8
    } blist_op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } blist_status_t;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } blist_state_t;

    typedef struct packed {
        logic [OPC_W-1:0]        opcode;
        logic signed [VAL_W-1:0] item_value;
        logic [POS_W-1:0]        position;
    } blist_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_value;
        logic [ST_W-1:0]         status;
        logic                    last_of_run;
        logic [LEN_W-1:0]        list_length;
    } blist_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;   // perform the incoming opcode and load its first result
        logic step;   // load the next entry of a list walk
    } blist_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_full;    // result register holds a beat not yet taken
        logic list_more;   // incoming opcode is a list walk of two or more beats
        logic list_last;   // next list beat is the final entry
    } blist_stat_t;

endpackage

FILE: rtl/bounded_ordered_list.sv
// Bounded ordered list, top level. Every opcode but list gives one result beat from the
// result register on the next cycle; a new opcode can be taken each cycle while that
// register is free. List walks the entry row through one read port, one beat per cycle
// while rsp_stall is low, and holds off new opcodes until its last beat is loaded.
// Reset clears the entry count and the result valid flag; stored entries are not cleared.
// Depends on blist_pkg, blist_ctrl and blist_dp.
module bounded_ordered_list (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  blist_pkg::blist_in_t  cmd,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output blist_pkg::blist_out_t rsp
);
    import blist_pkg::*;

    blist_cmd_t  ctl;
    blist_stat_t st;

    blist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_stall (rsp_stall),
        .st        (st),
        .ctl       (ctl)
    );

    blist_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .ctl       (ctl),
        .st        (st)
    );

endmodule

FILE: rtl/blist_ctrl.sv
// Controller for the bounded ordered list: sequences single-result opcodes
// and multi-beat list walks. Depends on blist_pkg.
module blist_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  logic                  rsp_stall,
    input  blist_pkg::blist_stat_t st,
    output blist_pkg::blist_cmd_t  ctl
);
    import blist_pkg::*;

    blist_state_t state_reg;
    blist_state_t state_next;
    logic         out_free;

    // The result register can take a new beat when empty or drained now.
    assign out_free = !st.out_full || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free && st.list_more)
                begin
                    state_next = S_LIST;
                end
            end
            S_LIST:
            begin
                if (out_free && st.list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_stall = 1'b1;
        ctl       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd_stall = !out_free;
                ctl.exec  = cmd_valid && out_free;
            end
            S_LIST:
            begin
                cmd_stall = 1'b1;
                ctl.step  = out_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/blist_dp.sv
// Datapath for the bounded ordered list: the entry register row, the
// count, the list-walk index and the result register. Depends on blist_pkg.
module blist_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  blist_pkg::blist_in_t   cmd,
    input  logic                  rsp_stall,
    output logic                  rsp_valid,
    output blist_pkg::blist_out_t  rsp,
    input  blist_pkg::blist_cmd_t  ctl,
    output blist_pkg::blist_stat_t st
);
    import blist_pkg::*;

    logic signed [VAL_W-1:0] row_reg  [CAPACITY];
    logic signed [VAL_W-1:0] row_next [CAPACITY];
    logic [IDX_W-1:0]        rev_sel  [CAPACITY];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  list_idx_reg;
    logic [IDX_W-1:0]  list_idx_next;
    logic              out_full_reg;
    logic              out_full_next;
    blist_out_t        rsp_reg;
    blist_out_t        rsp_next;

    logic              is_ins;
    logic              is_rem;
    logic              is_rev;
    logic              is_mid;
    logic              is_list;
    logic              full;
    logic              empty;
    logic [PCMP_W-1:0] pos_ext;
    logic [PCMP_W-1:0] cnt_ext;
    logic [PCMP_W-1:0] edit_pos;
    blist_status_t     op_status;
    logic              do_ins;
    logic              do_rem;
    logic              do_rev;
    logic [IDX_W-1:0]  rd_sel;
    logic signed [VAL_W-1:0] rd_data;

    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_ext = PCMP_W'(cmd.position);
    assign cnt_ext = PCMP_W'(count_reg);

    // Opcode decode and the position each edit works at.
    always_comb
    begin
        is_ins   = 1'b0;
        is_rem   = 1'b0;
        is_rev   = 1'b0;
        is_mid   = 1'b0;
        is_list  = 1'b0;
        edit_pos = '0;
        unique case (blist_op_t'(cmd.opcode))
            OP_APPEND:
            begin
                is_ins   = 1'b1;
                edit_pos = cnt_ext;
            end
            OP_PREPEND:
            begin
                is_ins   = 1'b1;
            end
            OP_INSERT:
            begin
                is_ins   = 1'b1;
                edit_pos = pos_ext;
            end
            OP_DROP_LAST:
            begin
                is_rem   = 1'b1;
                edit_pos = cnt_ext - PCMP_W'(1);
            end
            OP_DROP_FIRST:
            begin
                is_rem   = 1'b1;
            end
            OP_DROP_AT:
            begin
                is_rem   = 1'b1;
                edit_pos = pos_ext;
            end
            OP_REVERSE:
            begin
                is_rev   = 1'b1;
            end
            OP_MIDDLE:
            begin
                is_mid   = 1'b1;
            end
            OP_LIST:
            begin
                is_list  = 1'b1;
            end
            default:
            begin
                is_ins   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        op_status = ST_OK;
        if (is_ins)
        begin
            if (full)
                op_status = ST_FULL;
            else if (edit_pos > cnt_ext)
                op_status = ST_BADPOS;
        end
        else if (is_rem)
        begin
            if (empty)
                op_status = ST_EMPTY;
            else if (edit_pos >= cnt_ext)
                op_status = ST_BADPOS;
        end
        else if (is_mid || is_list)
        begin
            if (empty)
                op_status = ST_EMPTY;
        end
    end

    assign do_ins = ctl.exec && is_ins && (op_status == ST_OK);
    assign do_rem = ctl.exec && is_rem && (op_status == ST_OK);
    assign do_rev = ctl.exec && is_rev;

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
            count_next = count_reg + CNT_W'(1);
        else if (do_rem)
            count_next = count_reg - CNT_W'(1);
    end

    // Entries past the edit spot take the one below on insert, those from it on
    // the one above on delete; occupied entries take their mirror on reverse.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_row
        logic signed [VAL_W-1:0] below;
        logic signed [VAL_W-1:0] above;

        if (g > 0)
        begin : g_below
            assign below = row_reg[g-1];
        end
        else
        begin : g_below0
            assign below = row_reg[g];
        end

        if (g < CAPACITY - 1)
        begin : g_above
            assign above = row_reg[g+1];
        end
        else
        begin : g_aboveN
            assign above = row_reg[g];
        end

        assign rev_sel[g] = IDX_W'(count_reg - CNT_W'(1) - CNT_W'(g));

        always_comb
        begin
            row_next[g] = row_reg[g];
            if (do_ins)
            begin
                if (PCMP_W'(g) == edit_pos)
                    row_next[g] = cmd.item_value;
                else if (PCMP_W'(g) > edit_pos)
                    row_next[g] = below;
            end
            else if (do_rem)
            begin
                if (PCMP_W'(g) >= edit_pos)
                    row_next[g] = above;
            end
            else if (do_rev)
            begin
                if (PCMP_W'(g) < cnt_ext)
                    row_next[g] = row_reg[rev_sel[g]];
            end
        end

        always_ff @(posedge clk)
        begin
            row_reg[g] <= row_next[g];
        end
    end

    // One read port serves both the middle entry and the list walk.
    always_comb
    begin
        if (ctl.step)
            rd_sel = list_idx_reg;
        else if (is_mid)
            rd_sel = IDX_W'(count_reg >> 1);
        else
            rd_sel = '0;
    end

    assign rd_data = row_reg[rd_sel];

    always_comb
    begin
        list_idx_next = list_idx_reg;
        if (ctl.exec)
            list_idx_next = IDX_W'(1);
        else if (ctl.step)
            list_idx_next = list_idx_reg + IDX_W'(1);
    end

    always_comb
    begin
        rsp_next      = rsp_reg;
        out_full_next = out_full_reg && rsp_stall;
        if (ctl.exec)
        begin
            out_full_next        = 1'b1;
            rsp_next.out_value   = ((is_mid || is_list) && !empty) ? rd_data : '0;
            rsp_next.status      = op_status;
            rsp_next.last_of_run = !is_list || (count_reg <= CNT_W'(1));
            rsp_next.list_length = LEN_W'(count_next);
        end
        else if (ctl.step)
        begin
            out_full_next        = 1'b1;
            rsp_next.out_value   = rd_data;
            rsp_next.status      = ST_OK;
            rsp_next.last_of_run = st.list_last;
            rsp_next.list_length = LEN_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            out_full_reg <= out_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        list_idx_reg <= list_idx_next;
        rsp_reg      <= rsp_next;
    end

    assign st.out_full  = out_full_reg;
    assign st.list_more = is_list && (count_reg > CNT_W'(1));
    assign st.list_last = ((CNT_W'(list_idx_reg) + CNT_W'(1)) == count_reg);

    assign rsp_valid = out_full_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for bounded_ordered_list: random and directed list edits.
// A shadow list predicts every result beat, and a clocked monitor compares them.
// Depends on blist_pkg and the RTL top level bounded_ordered_list.
`timescale 1ns / 1ps

module testbench;
    import blist_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;
    localparam int FIRST_UNUSED_OP = int'(OP_LIST) + 1;
    localparam int LAST_OP_CODE    = (1 << OPC_W) - 1;

    typedef struct {
        blist_in_t beat;
        bit        drain_first;
    } pend_t;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    blist_in_t  cmd       = '0;
    logic       rsp_valid;
    logic       rsp_stall = 1'b0;
    blist_out_t rsp;

    pend_t      op_queue[$];
    blist_out_t pending_results[$];
    logic       cmd_fire = 1'b0;
    int         pushed_cnt   = 0;
    int         accepted_cnt = 0;
    int         error_count  = 0;
    int         quiet_cycles = 0;
    int         snd_idle_pct = 0;
    int         rcv_idle_pct = 0;

    // Shadow list used for prediction.
    logic signed [VAL_W-1:0] model_row [CAPACITY];
    int                      model_len = 0;

    // Length tracking on the stimulus side, so positions can be aimed at valid slots.
    int gen_len   = 0;
    bit grow_mode = 1'b1;

    bounded_ordered_list u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic blist_status_t list_insert(int at, logic signed [VAL_W-1:0] v);
        int i;
        if (model_len >= CAPACITY)
            return ST_FULL;
        if (at > model_len)
            return ST_BADPOS;
        for (i = model_len; i > at; i--)
            model_row[i] = model_row[i-1];
        model_row[at] = v;
        model_len++;
        return ST_OK;
    endfunction

    function automatic blist_status_t list_remove(int at);
        int i;
        if (model_len == 0)
            return ST_EMPTY;
        if (at >= model_len)
            return ST_BADPOS;
        for (i = at; i + 1 < model_len; i++)
            model_row[i] = model_row[i+1];
        model_len--;
        return ST_OK;
    endfunction

    // Applies one accepted opcode to the shadow list and queues the beats it must produce.
    task automatic apply_list_op(input blist_in_t b);
        blist_out_t              res;
        logic signed [VAL_W-1:0] swap;
        int                      i;
        res = '0;
        res.status = ST_OK;
        case (b.opcode)
            OP_APPEND:     res.status = list_insert(model_len, b.item_value);
            OP_PREPEND:    res.status = list_insert(0, b.item_value);
            OP_INSERT:     res.status = list_insert(int'(b.position), b.item_value);
            OP_DROP_LAST:  res.status = (model_len == 0) ? ST_EMPTY : list_remove(model_len - 1);
            OP_DROP_FIRST: res.status = list_remove(0);
            OP_DROP_AT:    res.status = list_remove(int'(b.position));
            OP_REVERSE:
            begin
                for (i = 0; i < model_len / 2; i++)
                begin
                    swap = model_row[i];
                    model_row[i] = model_row[model_len-1-i];
                    model_row[model_len-1-i] = swap;
                end
            end
            OP_MIDDLE:
            begin
                if (model_len == 0)
                    res.status = ST_EMPTY;
                else
                    res.out_value = model_row[model_len / 2];
            end
            OP_LIST:
            begin
                if (model_len == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    for (i = 0; i < model_len; i++)
                    begin
                        res.out_value   = model_row[i];
                        res.last_of_run = (i + 1 == model_len);
                        res.list_length = LEN_W'(model_len);
                        pending_results.push_back(res);
                    end
                    return;
                end
            end
            default: ;
        endcase
        res.last_of_run = 1'b1;
        res.list_length = LEN_W'(model_len);
        pending_results.push_back(res);
    endtask

    task automatic push_beat(input blist_in_t b, input bit drain_first);
        pend_t p;
        p.beat = b;
        p.drain_first = drain_first;
        op_queue.push_back(p);
        pushed_cnt++;
        case (b.opcode)
            OP_APPEND, OP_PREPEND:
                if (gen_len < CAPACITY) gen_len++;
            OP_INSERT:
                if (gen_len < CAPACITY && int'(b.position) <= gen_len) gen_len++;
            OP_DROP_LAST, OP_DROP_FIRST:
                if (gen_len > 0) gen_len--;
            OP_DROP_AT:
                if (gen_len > 0 && int'(b.position) < gen_len) gen_len--;
            default: ;
        endcase
    endtask

    task automatic push_op(input blist_op_t op, input logic signed [VAL_W-1:0] v,
                           input int pos);
        blist_in_t b;
        b.opcode     = op;
        b.item_value = v;
        b.position   = POS_W'(pos);
        push_beat(b, 1'b0);
    endtask

    // Mostly grow-then-shrink sweeps with random content, so the list reaches both
    // full and empty; a share of reads, bad positions and unused opcodes is mixed in.
    task automatic gen_random(input int n, input bit hold_first);
        blist_in_t b;
        int        k;
        int        pick;
        for (k = 0; k < n; k++)
        begin
            if (grow_mode && gen_len == CAPACITY && $urandom_range(2) == 0)
                grow_mode = 1'b0;
            else if (!grow_mode && gen_len == 0 && $urandom_range(2) == 0)
                grow_mode = 1'b1;
            else if ($urandom_range(39) == 0)
                grow_mode = !grow_mode;

            b.position = POS_W'($urandom_range(LAST_OP_CODE * 4 + 3));
            if ($urandom_range(7) == 0)
            begin
                case ($urandom_range(3))
                    0: b.item_value = 32'sh7FFF_FFFF;
                    1: b.item_value = 32'sh8000_0000;
                    2: b.item_value = '0;
                    default: b.item_value = '1;
                endcase
            end
            else
                b.item_value = $urandom();

            pick = $urandom_range(99);
            if (pick < 12)
                b.opcode = OPC_W'(int'(OP_REVERSE) + $urandom_range(2));
            else if (pick < 15)
                b.opcode = OPC_W'($urandom_range(LAST_OP_CODE, FIRST_UNUSED_OP));
            else if (pick < (grow_mode ? 82 : 30))
            begin
                b.opcode = OPC_W'(int'(OP_APPEND) + $urandom_range(2));
                if ($urandom_range(9) != 0)
                    b.position = POS_W'($urandom_range(gen_len));
            end
            else
            begin
                b.opcode = OPC_W'(int'(OP_DROP_LAST) + $urandom_range(2));
                if (gen_len > 0 && $urandom_range(9) != 0)
                    b.position = POS_W'($urandom_range(gen_len - 1));
            end
            push_beat(b, (hold_first && k == 0) || $urandom_range(49) == 0);
        end
    endtask

    // Driver: new beats and stall changes go out on the falling edge.
    always @(negedge clk)
    begin
        pend_t nxt;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            rsp_stall <= 1'b0;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
            if (!cmd_valid || cmd_fire)
            begin
                if (op_queue.size() == 0 || $urandom_range(99) < snd_idle_pct
                    || (op_queue[0].drain_first && pending_results.size() != 0))
                    cmd_valid <= 1'b0;
                else
                begin
                    nxt = op_queue.pop_front();
                    cmd       <= nxt.beat;
                    cmd_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: predicts on each accepted command beat and checks each accepted result.
    always @(posedge clk)
    begin
        blist_out_t want;
        bit         bad;
        if (!rst_n)
            cmd_fire <= 1'b0;
        else
        begin
            cmd_fire <= cmd_valid && !cmd_stall;
            if (cmd_valid && !cmd_stall)
            begin
                apply_list_op(cmd);
                accepted_cnt++;
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, got value %0d status %0d",
                             $time, rsp.out_value, rsp.status);
                    error_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    bad  = 1'b0;
                    if (rsp.out_value !== want.out_value)
                    begin
                        $display("%0t: out_value expected %0d got %0d",
                                 $time, want.out_value, rsp.out_value);
                        bad = 1'b1;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, rsp.status);
                        bad = 1'b1;
                    end
                    if (rsp.last_of_run !== want.last_of_run)
                    begin
                        $display("%0t: last_of_run expected %0d got %0d",
                                 $time, want.last_of_run, rsp.last_of_run);
                        bad = 1'b1;
                    end
                    if (rsp.list_length !== want.list_length)
                    begin
                        $display("%0t: list_length expected %0d got %0d",
                                 $time, want.list_length, rsp.list_length);
                        bad = 1'b1;
                    end
                    if (bad)
                        error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither channel moves a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        snd_idle_pct = 16;
        rcv_idle_pct = 78;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty-list cases first, then edge values and positions on a short list.
        push_op(OP_MIDDLE, 0, 0);
        push_op(OP_LIST, 0, 0);
        push_op(OP_DROP_LAST, 0, 0);
        push_op(OP_DROP_FIRST, 0, 0);
        push_op(OP_DROP_AT, 0, 0);
        push_op(OP_REVERSE, 0, 0);
        push_op(OP_APPEND, 32'sh7FFF_FFFF, 0);
        push_op(OP_REVERSE, 0, 0);
        push_op(OP_PREPEND, 32'sh8000_0000, 0);
        push_op(OP_INSERT, 0, 2);
        push_op(OP_INSERT, -1, (1 << POS_W) - 1);
        push_op(OP_INSERT, 5, 4);
        push_op(OP_INSERT, 32'sh5555_AAAA, 1);
        push_op(OP_MIDDLE, 0, 0);
        push_op(OP_LIST, 0, 0);
        push_op(OP_REVERSE, 0, 0);
        push_op(OP_LIST, 0, 0);
        push_op(OP_DROP_AT, 0, (1 << POS_W) - 1);
        push_op(OP_DROP_AT, 0, 4);
        push_op(OP_DROP_AT, 0, 1);
        push_op(OP_DROP_LAST, 0, 0);
        push_op(OP_DROP_FIRST, 0, 0);
        push_op(blist_op_t'(LAST_OP_CODE), -1, (1 << POS_W) - 1);
        push_op(blist_op_t'(FIRST_UNUSED_OP), 32'sh1234_5678, 0);
        push_op(OP_MIDDLE, 0, 0);

        gen_random(50, 1'b0);
        while (accepted_cnt != pushed_cnt)
            @(negedge clk);

        snd_idle_pct = 78;
        rcv_idle_pct = 16;
        gen_random(48, 1'b1);
        while (accepted_cnt != pushed_cnt)
            @(negedge clk);

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        gen_random(47, 1'b1);
        while (accepted_cnt != pushed_cnt || pending_results.size() != 0)
            @(negedge clk);

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
